/* rtl/core/rfc_pkg.sv */
// shared types and constants for the radio frame checker
`default_nettype none

package rfc_pkg;

	localparam int BYTE_W = 8;
	localparam int CFG_ADDR_W = 2;

	localparam logic [BYTE_W-1:0] START_MARK = 8'h2A;
	localparam logic [BYTE_W-1:0] END_MARK = 8'h23;

	localparam logic [CFG_ADDR_W-1:0] CFG_OWN_ADDR = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_BCAST_A = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_BCAST_B = 2'd2;

	localparam logic [BYTE_W-1:0] OWN_ADDR_RST = 8'd0;
	localparam logic [BYTE_W-1:0] BCAST_A_RST = 8'd255;
	localparam logic [BYTE_W-1:0] BCAST_B_RST = 8'd254;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_DEST = 3'd1,
		PH_SRC  = 3'd2,
		PH_LEN  = 3'd3,
		PH_PAY  = 3'd4,
		PH_SUM  = 3'd5,
		PH_END  = 3'd6
	} phase_t;

	typedef enum logic [2:0] {
		ROLE_START   = 3'd0,
		ROLE_DEST    = 3'd1,
		ROLE_SRC     = 3'd2,
		ROLE_LEN     = 3'd3,
		ROLE_PAYLOAD = 3'd4,
		ROLE_SUM     = 3'd5,
		ROLE_END     = 3'd6,
		ROLE_IGNORE  = 3'd7
	} role_t;

	typedef enum logic [2:0] {
		ST_ACCEPT    = 3'd0,
		ST_BAD_START = 3'd1,
		ST_BAD_END   = 3'd2,
		ST_CHECKSUM  = 3'd3,
		ST_NOT_ADDR  = 3'd4
	} status_t;

	typedef struct packed {
		logic [BYTE_W-1:0] own_address;
		logic [BYTE_W-1:0] broadcast_address_a;
		logic [BYTE_W-1:0] broadcast_address_b;
	} cfg_t;

	// packed so that {status, done_res, role} sits above data_byte
	typedef struct packed {
		status_t           status;
		logic              done_res;
		role_t             role;
		logic [BYTE_W-1:0] data_byte;
	} res_t;

endpackage

`default_nettype wire

/* rtl/core/rfc_cfg_regs.sv */
// configuration register file for the radio frame checker
`default_nettype none

module rfc_cfg_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	input  wire logic [rfc_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [rfc_pkg::BYTE_W-1:0]     cfg_data,
	output rfc_pkg::cfg_t                       cfg
);
	import rfc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_address <= OWN_ADDR_RST;
			cfg_q.broadcast_address_a <= BCAST_A_RST;
			cfg_q.broadcast_address_b <= BCAST_B_RST;
		end else if (cfg_valid) begin
			unique case (cfg_addr)
				CFG_OWN_ADDR: cfg_q.own_address <= cfg_data;
				CFG_BCAST_A:  cfg_q.broadcast_address_a <= cfg_data;
				CFG_BCAST_B:  cfg_q.broadcast_address_b <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* rtl/core/rfc_in_stage.sv */
// input register stage holding one received byte
`default_nettype none

module rfc_in_stage (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	input  wire logic [rfc_pkg::BYTE_W-1:0] rx_byte,
	input  wire logic                       first_byte,
	input  wire logic                       take,
	output logic                            valid_s1,
	output logic [rfc_pkg::BYTE_W-1:0]      byte_s1,
	output logic                            first_s1
);
	import rfc_pkg::*;

	logic valid_q;

	// refill in the same cycle the held item moves on
	assign s_tready = !valid_q || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (s_tready) begin
			valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= rx_byte;
			first_s1 <= first_byte;
		end
	end

	assign valid_s1 = valid_q;

endmodule

`default_nettype wire

/* rtl/core/rfc_parser.sv */
// frame position tracking, checksum and verdict logic
`default_nettype none

module rfc_parser (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       step,
	input  wire logic [rfc_pkg::BYTE_W-1:0] rx_byte,
	input  wire logic                       first_byte,
	input  wire rfc_pkg::cfg_t              cfg,
	output rfc_pkg::res_t                   res
);
	import rfc_pkg::*;

	phase_t            phase_q, phase_d;
	logic [BYTE_W-1:0] bytes_left_q, bytes_left_d;
	logic [BYTE_W-1:0] sum_q, sum_d;
	logic              hit_q, hit_d;
	logic              sum_ok_q, sum_ok_d;
	logic [BYTE_W-1:0] left_dec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bytes_left_q <= '0;
			sum_q <= '0;
			hit_q <= 1'b0;
			sum_ok_q <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			bytes_left_q <= bytes_left_d;
			sum_q <= sum_d;
			hit_q <= hit_d;
			sum_ok_q <= sum_ok_d;
		end
	end

	assign left_dec = bytes_left_q - 8'd1;

	always_comb begin
		phase_d = phase_q;
		bytes_left_d = bytes_left_q;
		sum_d = sum_q;
		hit_d = hit_q;
		sum_ok_d = sum_ok_q;
		res.data_byte = rx_byte;
		res.role = ROLE_IGNORE;
		res.done_res = 1'b0;
		res.status = ST_ACCEPT;

		if (first_byte) begin
			// a first byte restarts parsing whatever the phase
			res.role = ROLE_START;
			sum_d = '0;
			bytes_left_d = '0;
			hit_d = 1'b0;
			sum_ok_d = 1'b0;
			if (rx_byte == START_MARK) begin
				phase_d = PH_DEST;
			end else begin
				res.done_res = 1'b1;
				res.status = ST_BAD_START;
				phase_d = PH_IDLE;
			end
		end else begin
			unique case (phase_q)
				PH_DEST: begin
					res.role = ROLE_DEST;
					hit_d = (rx_byte == cfg.own_address)
						|| (rx_byte == cfg.broadcast_address_a)
						|| (rx_byte == cfg.broadcast_address_b);
					phase_d = PH_SRC;
				end
				PH_SRC: begin
					res.role = ROLE_SRC;
					phase_d = PH_LEN;
				end
				PH_LEN: begin
					res.role = ROLE_LEN;
					bytes_left_d = rx_byte;
					sum_d = '0;
					phase_d = (rx_byte == '0) ? PH_SUM : PH_PAY;
				end
				PH_PAY: begin
					res.role = ROLE_PAYLOAD;
					sum_d = sum_q + rx_byte;
					bytes_left_d = left_dec;
					if (left_dec == '0) begin
						phase_d = PH_SUM;
					end
				end
				PH_SUM: begin
					res.role = ROLE_SUM;
					sum_ok_d = (rx_byte == sum_q);
					phase_d = PH_END;
				end
				PH_END: begin
					res.role = ROLE_END;
					res.done_res = 1'b1;
					if (rx_byte != END_MARK) begin
						res.status = ST_BAD_END;
					end else if (!sum_ok_q) begin
						res.status = ST_CHECKSUM;
					end else if (!hit_q) begin
						res.status = ST_NOT_ADDR;
					end else begin
						res.status = ST_ACCEPT;
					end
					phase_d = PH_IDLE;
				end
				default: begin
					res.role = ROLE_IGNORE;
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	a_done_role: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res.done_res) |-> (res.role == ROLE_START || res.role == ROLE_END))
		else $error("verdict on a byte that is neither start nor end");

	a_status_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !res.done_res) |-> (res.status == ST_ACCEPT))
		else $error("status set without a verdict");

	a_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !first_byte && phase_q == PH_LEN && rx_byte == '0)
		|=> (phase_q == PH_SUM))
		else $error("zero length frame did not go to checksum");

	a_verdict_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res.done_res) |=> (phase_q == PH_IDLE))
		else $error("parser not idle after a verdict");

endmodule

`default_nettype wire

/* rtl/core/rfc_out_stage.sv */
// result register driving the output stream
`default_nettype none

module rfc_out_stage (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          load,
	input  wire rfc_pkg::res_t res,
	output logic               ready,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output rfc_pkg::res_t      res_q
);
	import rfc_pkg::*;

	logic valid_q;

	assign ready = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && load) begin
			res_q <= res;
		end
	end

	assign m_tvalid = valid_q;

endmodule

`default_nettype wire

/* rtl/core/radio_frame_checker_core.sv */
// top level of the radio frame checker
//
// Received bytes enter on the s_ stream, one byte per item; s_tuser flags
// the first byte of a new frame. Every byte comes back out on the m_ stream
// with its role in the frame and, on the byte that closes the frame, a
// verdict (accepted, bad start, bad end, checksum, not addressed).
// An item passes from input accept to output accept through the input
// register and then the result register; m_tvalid rises with its result in
// the result register. The parser handles one byte per cycle, so a new item
// is taken every cycle while the output flows.
// When the receiver holds m_tready low the result register holds, the
// input register fills behind it and s_tready drops; nothing is lost.
// Reset clears both valid flags, puts the parser in the ignoring phase
// and loads own address 0 and broadcast addresses 255 and 254.
// Configuration writes on cfg_ are always ready and take effect at once;
// they are meant for when the stream is idle.
`default_nettype none

module radio_frame_checker_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [7:0]                     s_tdata,  // [7:0] rx_byte
	input  wire logic                           s_tuser,  // [0] first_byte
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [7:0]                          m_tdata,  // [7:0] data_byte
	output logic [6:0]                          m_tuser,  // [2:0] role, [3] done_res, [6:4] status
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [rfc_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [7:0]                     cfg_data
);
	import rfc_pkg::*;

	cfg_t              cfg;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              first_s1;
	logic              out_ready;
	logic              step;
	res_t              res;
	res_t              res_q;

	assign cfg_ready = 1'b1;
	assign step = valid_s1 && out_ready;

	rfc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rfc_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.rx_byte    (s_tdata),
		.first_byte (s_tuser),
		.take       (out_ready),
		.valid_s1   (valid_s1),
		.byte_s1    (byte_s1),
		.first_s1   (first_s1)
	);

	rfc_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.rx_byte    (byte_s1),
		.first_byte (first_s1),
		.cfg        (cfg),
		.res        (res)
	);

	rfc_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (valid_s1),
		.res      (res),
		.ready    (out_ready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.res_q    (res_q)
	);

	assign m_tdata = res_q.data_byte;
	assign m_tuser = {res_q.status, res_q.done_res, res_q.role};

endmodule

`default_nettype wire

/* dv/frame_verdict_checker.sv */
// checker for the radio frame checker: predicts each echoed item and compares it
module frame_verdict_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [7:0]                     s_tdata,  // [7:0] rx_byte
	input  logic                           s_tuser,  // [0] first_byte
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [7:0]                     m_tdata,  // [7:0] data_byte
	input  logic [6:0]                     m_tuser,  // [2:0] role, [3] done_res, [6:4] status
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [rfc_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [7:0]                     cfg_data,
	output int                             err_count,
	output int                             pending
);
	import rfc_pkg::*;

	logic [7:0] node_addr;
	logic [7:0] bcast_a;
	logic [7:0] bcast_b;

	phase_t     parse_phase;
	logic [7:0] payload_left;
	logic [7:0] payload_sum;
	logic       dest_hit;
	logic       sum_match;

	res_t expected_echo[$];

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		err_count++;
	endtask

	// advances the parser copy by one byte and returns the echo it should give
	function automatic res_t predict_echo(input logic [7:0] rx, input logic first);
		res_t r;
		r.data_byte = rx;
		r.role = ROLE_IGNORE;
		r.done_res = 1'b0;
		r.status = ST_ACCEPT;
		if (first) begin
			r.role = ROLE_START;
			payload_sum = '0;
			payload_left = '0;
			dest_hit = 1'b0;
			sum_match = 1'b0;
			if (rx == START_MARK) begin
				parse_phase = PH_DEST;
			end else begin
				r.done_res = 1'b1;
				r.status = ST_BAD_START;
				parse_phase = PH_IDLE;
			end
		end else begin
			case (parse_phase)
				PH_DEST: begin
					r.role = ROLE_DEST;
					dest_hit = (rx == node_addr) || (rx == bcast_a) || (rx == bcast_b);
					parse_phase = PH_SRC;
				end
				PH_SRC: begin
					r.role = ROLE_SRC;
					parse_phase = PH_LEN;
				end
				PH_LEN: begin
					r.role = ROLE_LEN;
					payload_left = rx;
					payload_sum = '0;
					parse_phase = (rx == 8'd0) ? PH_SUM : PH_PAY;
				end
				PH_PAY: begin
					r.role = ROLE_PAYLOAD;
					payload_sum = payload_sum + rx;
					payload_left = payload_left - 8'd1;
					if (payload_left == 8'd0)
						parse_phase = PH_SUM;
				end
				PH_SUM: begin
					r.role = ROLE_SUM;
					sum_match = (rx == payload_sum);
					parse_phase = PH_END;
				end
				PH_END: begin
					r.role = ROLE_END;
					r.done_res = 1'b1;
					// verdict priority: end mark, then checksum, then address
					if (rx != END_MARK)
						r.status = ST_BAD_END;
					else if (!sum_match)
						r.status = ST_CHECKSUM;
					else if (!dest_hit)
						r.status = ST_NOT_ADDR;
					parse_phase = PH_IDLE;
				end
				default: begin
					parse_phase = PH_IDLE;
				end
			endcase
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		res_t want;
		if (!arst_n) begin
			node_addr = OWN_ADDR_RST;
			bcast_a = BCAST_A_RST;
			bcast_b = BCAST_B_RST;
			parse_phase = PH_IDLE;
			payload_left = '0;
			payload_sum = '0;
			dest_hit = 1'b0;
			sum_match = 1'b0;
			expected_echo.delete();
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_addr)
					CFG_OWN_ADDR: node_addr = cfg_data;
					CFG_BCAST_A:  bcast_a = cfg_data;
					CFG_BCAST_B:  bcast_b = cfg_data;
					default: ;
				endcase
			end
			// output first: an item taken on this edge cannot leave on it
			if (m_tvalid && m_tready) begin
				if (expected_echo.size() == 0) begin
					report_mismatch("unexpected item, data_byte", int'(m_tdata), -1);
				end else begin
					want = expected_echo.pop_front();
					if (m_tdata !== want.data_byte)
						report_mismatch("data_byte", int'(m_tdata), int'(want.data_byte));
					if (m_tuser[2:0] !== want.role)
						report_mismatch("role", int'(m_tuser[2:0]), int'(want.role));
					if (m_tuser[3] !== want.done_res)
						report_mismatch("done_res", int'(m_tuser[3]), int'(want.done_res));
					if (m_tuser[6:4] !== want.status)
						report_mismatch("status", int'(m_tuser[6:4]), int'(want.status));
				end
			end
			if (s_tvalid && s_tready)
				expected_echo.push_back(predict_echo(s_tdata, s_tuser));
			pending = expected_echo.size();
		end
	end

	initial err_count = 0;

endmodule

/* dv/testbench.sv */
// top of the radio frame checker testbench: stimulus, idling and verdict
module testbench;
	import rfc_pkg::*;

	typedef enum {
		FR_GOOD,
		FR_BAD_START,
		FR_BAD_END,
		FR_BAD_SUM,
		FR_CUT,
		FR_NOISE
	} frame_kind_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [7:0]            s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [7:0]            m_tdata;
	logic [6:0]            m_tuser;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [7:0]            cfg_data;

	int err_count;
	int pending;
	int send_idle;
	int recv_idle;
	int sent_items;

	// addresses currently programmed, used to aim frames
	logic [7:0] node_addr;
	logic [7:0] bcast_a;
	logic [7:0] bcast_b;

	radio_frame_checker_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data)
	);

	frame_verdict_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.err_count (err_count),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle);
	end

	initial begin
		#3000000;
		$display("Regression FAIL");
		$finish;
	end

	// called at a falling edge, returns at the falling edge after the accept
	task automatic send_byte(input logic [7:0] rx, input logic first);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= rx;
		s_tuser <= first;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
		sent_items++;
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic apply_addresses(input logic [7:0] own, input logic [7:0] ba,
			input logic [7:0] bb);
		logic [CFG_ADDR_W-1:0] idx[3];
		logic [7:0]            val[3];
		idx = '{CFG_OWN_ADDR, CFG_BCAST_A, CFG_BCAST_B};
		val = '{own, ba, bb};
		drain();
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_addr <= idx[i];
			cfg_data <= val[i];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
		node_addr = own;
		bcast_a = ba;
		bcast_b = bb;
	endtask

	task automatic send_frame(input frame_kind_t kind);
		logic [7:0] fb[$];
		logic [7:0] len;
		logic [7:0] sum;
		logic [7:0] rx;
		int         roll;
		int         count;
		case (kind)
			FR_NOISE: begin
				send_byte(8'($urandom_range(255)), 1'b0);
			end
			FR_BAD_START: begin
				rx = 8'($urandom_range(255));
				if (rx == START_MARK)
					rx = 8'h00;
				send_byte(rx, 1'b1);
			end
			default: begin
				roll = $urandom_range(99);
				if (roll == 0)
					len = 8'd255;
				else if (roll == 1)
					len = 8'($urandom_range(9, 254));
				else if (roll < 12)
					len = 8'd0;
				else
					len = 8'($urandom_range(1, 8));
				fb.push_back(START_MARK);
				case ($urandom_range(3))
					0: fb.push_back(node_addr);
					1: fb.push_back(bcast_a);
					2: fb.push_back(bcast_b);
					default: fb.push_back(8'($urandom_range(255)));
				endcase
				fb.push_back(8'($urandom_range(255)));
				fb.push_back(len);
				sum = '0;
				for (int i = 0; i < int'(len); i++) begin
					rx = 8'($urandom_range(255));
					sum = sum + rx;
					fb.push_back(rx);
				end
				if (kind == FR_BAD_SUM)
					sum = sum + 8'($urandom_range(1, 255));
				fb.push_back(sum);
				if (kind == FR_BAD_END)
					fb.push_back(END_MARK ^ 8'($urandom_range(1, 255)));
				else
					fb.push_back(END_MARK);
				count = (kind == FR_CUT) ? $urandom_range(1, fb.size() - 1) : fb.size();
				for (int i = 0; i < count; i++)
					send_byte(fb[i], i == 0);
			end
		endcase
	endtask

	task automatic random_frames(input int quota, input bit hold_midway);
		int          goal;
		int          roll;
		bit          held;
		frame_kind_t kind;
		goal = sent_items + quota;
		held = 1'b0;
		while (sent_items < goal) begin
			roll = $urandom_range(99);
			if (roll < 60)
				kind = FR_GOOD;
			else if (roll < 68)
				kind = FR_BAD_START;
			else if (roll < 76)
				kind = FR_BAD_END;
			else if (roll < 84)
				kind = FR_BAD_SUM;
			else if (roll < 92)
				kind = FR_CUT;
			else
				kind = FR_NOISE;
			send_frame(kind);
			// let the output side empty completely once
			if (hold_midway && !held && sent_items >= goal - quota / 2) begin
				drain();
				held = 1'b1;
			end
		end
	endtask

	initial begin
		// bit 8 is first_byte
		logic [8:0] directed[30];
		directed = '{
			{1'b0, 8'hFF},
			{1'b1, START_MARK}, 9'h0FE, 9'h000, 9'h000, 9'h000, {1'b0, END_MARK},
			9'h100, {1'b0, END_MARK},
			{1'b1, START_MARK}, 9'h001, 9'h0FF, 9'h001, 9'h0FF, 9'h0FF, {1'b0, END_MARK},
			{1'b1, START_MARK}, 9'h0FF,
			{1'b1, START_MARK}, 9'h0FF, 9'h080, 9'h000, 9'h001, {1'b0, END_MARK},
			{1'b1, START_MARK}, 9'h000, 9'h07F, 9'h000, 9'h000, 9'h000
		};
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		cfg_valid = 1'b0;
		cfg_addr = '0;
		cfg_data = '0;
		sent_items = 0;
		send_idle = 25;
		recv_idle = 88;
		node_addr = OWN_ADDR_RST;
		bcast_a = BCAST_A_RST;
		bcast_b = BCAST_B_RST;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed[i])
			send_byte(directed[i][7:0], directed[i][8]);

		apply_addresses(8'hFF, 8'h00, 8'h00);
		random_frames(540, 1'b0);

		send_idle = 88;
		recv_idle = 25;
		apply_addresses(8'h00, 8'($urandom_range(255)), 8'hFF);
		random_frames(540, 1'b1);

		send_idle = 0;
		recv_idle = 0;
		apply_addresses(8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)));
		random_frames(540, 1'b0);

		s_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/rfc_pkg.sv
rtl/core/rfc_cfg_regs.sv
rtl/core/rfc_in_stage.sv
rtl/core/rfc_parser.sv
rtl/core/rfc_out_stage.sv
rtl/core/radio_frame_checker_core.sv
dv/frame_verdict_checker.sv
dv/testbench.sv
